[design/fdlr_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, widths and types for the fractional delay line reader.
// No dependencies; fdlr_interp and the top level import this package.
package fdlr_pkg;

  // Ring geometry: slot = low bits of the absolute index (depth is a power of two).
  localparam int RING_DEPTH = 131072;
  localparam int SLOT_W     = $clog2(RING_DEPTH);
  localparam int IDX_W      = 32;
  localparam int TAG_HI_W   = IDX_W - SLOT_W;
  localparam int TAG_W      = TAG_HI_W + 1;  // valid bit on top of the upper index bits

  // Field widths.
  localparam int SAMPLE_W   = 16;
  localparam int DELAY_W    = 24;
  localparam int GAIN_W     = 16;
  localparam int FRAC_W     = 8;
  localparam int POS_W      = IDX_W + FRAC_W;
  localparam int WEIGHT_W   = FRAC_W + 1;
  localparam int INTERP_W   = SAMPLE_W + WEIGHT_W;
  localparam int PROD_W     = INTERP_W + GAIN_W + 1;
  localparam int ROUND_SH   = 20;
  localparam int Y_W        = PROD_W - ROUND_SH;

  // Request kinds.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // Stage enables from the sequencer to the arithmetic pipeline.
  typedef struct packed {
    logic cap0;  // lower neighbour data is on the memory outputs
    logic mix;   // upper neighbour data is on the memory outputs
    logic gain;  // apply the gain to the interpolated value
  } fdlr_step_t;

endpackage

[design/fdlr_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
module fdlr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/fdlr_interp.sv]
`timescale 1ns / 1ps
// Neighbour presence check, linear interpolation, gain, rounding and saturation.
// Depends on fdlr_pkg; fed from the tag and sample memories of the top level.
module fdlr_interp (
  input  logic                              clk,
  input  fdlr_pkg::fdlr_step_t              step,
  input  logic [fdlr_pkg::TAG_W-1:0]        tag_rdata,
  input  logic signed [fdlr_pkg::SAMPLE_W-1:0] smp_rdata,
  input  logic [fdlr_pkg::IDX_W-1:0]        k0,
  input  logic [fdlr_pkg::IDX_W:0]          k1,
  input  logic [fdlr_pkg::FRAC_W-1:0]       frac,
  input  logic                              neg,
  input  logic [fdlr_pkg::GAIN_W-1:0]       gain,
  output logic signed [fdlr_pkg::SAMPLE_W-1:0] y_sat,
  output logic                              missed
);
  import fdlr_pkg::*;

  localparam logic [WEIGHT_W-1:0] FULL_WEIGHT = WEIGHT_W'(1 << FRAC_W);
  localparam logic signed [Y_W-1:0] Y_MAX = Y_W'(32767);
  localparam logic signed [Y_W-1:0] Y_MIN = -Y_W'(32768);
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (ROUND_SH - 1);

  logic [TAG_W-1:0]           tag0_r;
  logic signed [SAMPLE_W-1:0] s0_r;
  logic signed [INTERP_W-1:0] interp_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic                       missed_r;

  logic                       ok0, ok1;
  logic signed [SAMPLE_W-1:0] s0e, s1e;
  logic [WEIGHT_W-1:0]        m0, m1;
  logic signed [INTERP_W-1:0] interp_nxt;
  logic signed [PROD_W-1:0]   prod_nxt;
  logic signed [PROD_W-1:0]   rsum;
  logic signed [Y_W-1:0]      y;

  // Hold the lower neighbour while the upper one is fetched.
  always_ff @(posedge clk) begin
    if (step.cap0) begin
      tag0_r <= tag_rdata;
      s0_r   <= smp_rdata;
    end
  end

  assign ok0 = !neg && tag0_r[TAG_HI_W] && (tag0_r[TAG_HI_W-1:0] == k0[IDX_W-1:SLOT_W]);
  // The upper neighbour does not exist past the top of the index range.
  assign ok1 = !neg && !k1[IDX_W] && tag_rdata[TAG_HI_W] &&
               (tag_rdata[TAG_HI_W-1:0] == k1[IDX_W-1:SLOT_W]);

  // Drop absent samples to zero so unwritten entries never reach the sum.
  assign s0e = ok0 ? s0_r : '0;
  assign s1e = ok1 ? smp_rdata : '0;

  always_comb begin
    m0 = '0;
    m1 = '0;
    if (ok0 && ok1) begin
      m0 = FULL_WEIGHT - WEIGHT_W'(frac);
      m1 = WEIGHT_W'(frac);
    end else if (ok0) begin
      m0 = FULL_WEIGHT;
    end else if (ok1) begin
      m1 = FULL_WEIGHT;
    end
  end

  assign interp_nxt =
      $signed({{WEIGHT_W{s0e[SAMPLE_W-1]}}, s0e}) * $signed({{SAMPLE_W{1'b0}}, m0}) +
      $signed({{WEIGHT_W{s1e[SAMPLE_W-1]}}, s1e}) * $signed({{SAMPLE_W{1'b0}}, m1});

  assign prod_nxt =
      $signed({{(PROD_W-INTERP_W){interp_r[INTERP_W-1]}}, interp_r}) *
      $signed({{(PROD_W-GAIN_W){1'b0}}, gain});

  always_ff @(posedge clk) begin
    if (step.mix) begin
      interp_r <= interp_nxt;
      missed_r <= !(ok0 && ok1);
    end
    if (step.gain) begin
      prod_r <= prod_nxt;
    end
  end

  // Round half up, floor by the arithmetic shift, then clamp.
  assign rsum = prod_r + HALF;
  assign y    = rsum[PROD_W-1:ROUND_SH];

  always_comb begin
    if (y > Y_MAX) begin
      y_sat = Y_MAX[SAMPLE_W-1:0];
    end else if (y < Y_MIN) begin
      y_sat = Y_MIN[SAMPLE_W-1:0];
    end else begin
      y_sat = y[SAMPLE_W-1:0];
    end
  end

  assign missed = missed_r;

endmodule

[design/fractional_delay_line_reader.sv]
`timescale 1ns / 1ps
// Top level of the fractional delay line reader: sequencer, tag and sample memories,
// output register. Depends on fdlr_pkg, fdlr_ram and fdlr_interp.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------------
//   in_     | input     | in_valid/in_stall   | action, sample_index, sample_value,
//           |           |                    | delay, gain
//   out_    | output    | out_valid/out_stall | sample, missed, newest_index, newest_valid
//
// A write request completes at the accept edge, where both memories are written.
// A read request steps through ST_FETCH0, ST_FETCH1, ST_MIX, ST_GAIN and ST_DONE to
// the result register with in_stall high throughout, so no new request is taken
// before it finishes. Its two neighbour lookups go one after the other through the
// single read port of the tag and sample memories, followed by the interpolation and
// gain stages. After reset the tag memory is swept clear, one entry a cycle, over all
// RING_DEPTH (131072) entries; in_stall stays high during the sweep.
// A waiting result does not block new requests by itself; a read that finishes while
// the output register is still full holds in its last stage, with in_stall high,
// until out_stall drops.
module fractional_delay_line_reader (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_action,
  input  logic [fdlr_pkg::IDX_W-1:0]           in_sample_index,
  input  logic signed [fdlr_pkg::SAMPLE_W-1:0] in_sample_value,
  input  logic [fdlr_pkg::DELAY_W-1:0]         in_delay,
  input  logic [fdlr_pkg::GAIN_W-1:0]          in_gain,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [fdlr_pkg::SAMPLE_W-1:0] out_sample,
  output logic                                 out_missed,
  output logic [fdlr_pkg::IDX_W-1:0]           out_newest_index,
  output logic                                 out_newest_valid
);
  import fdlr_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_FETCH0 = 7'b0000100,
    ST_FETCH1 = 7'b0001000,
    ST_MIX    = 7'b0010000,
    ST_GAIN   = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_DEPTH - 1);

  state_t                     state_r, state_nxt;
  logic [SLOT_W-1:0]          clr_cnt_r;
  logic [IDX_W-1:0]           newest_idx_r;
  logic                       newest_vld_r;

  // Captured read request.
  logic [IDX_W-1:0]           k0_r;
  logic [FRAC_W-1:0]          frac_r;
  logic                       neg_r;
  logic [GAIN_W-1:0]          gain_r;
  logic [IDX_W-1:0]           snap_idx_r;
  logic                       snap_vld_r;

  // Output register.
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_missed_r;
  logic [IDX_W-1:0]           out_newest_idx_r;
  logic                       out_newest_vld_r;

  logic                       in_acc;
  logic                       wr_acc;
  logic                       rd_acc;
  logic                       out_load;
  logic [POS_W:0]             pos_diff;
  logic [IDX_W:0]             k1;

  logic                       tag_we;
  logic [SLOT_W-1:0]          tag_waddr;
  logic [TAG_W-1:0]           tag_wdata;
  logic [SLOT_W-1:0]          rd_addr;
  logic [TAG_W-1:0]           tag_rdata;
  logic [SAMPLE_W-1:0]        smp_rdata;
  fdlr_step_t                 step;
  logic signed [SAMPLE_W-1:0] y_sat;
  logic                       missed;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign wr_acc   = in_acc && (in_action == ACT_WRITE);
  assign rd_acc   = in_acc && (in_action == ACT_READ);

  // Read position in Q.8; the top bit is the borrow that flags a negative position.
  assign pos_diff = {1'b0, in_sample_index, {FRAC_W{1'b0}}} -
                    {{(POS_W + 1 - DELAY_W){1'b0}}, in_delay};
  assign k1       = {1'b0, k0_r} + {{IDX_W{1'b0}}, 1'b1};

  // Load the result once the output register is free.
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == SLOT_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (rd_acc) begin
          state_nxt = ST_FETCH0;
        end
      end
      ST_FETCH0: state_nxt = ST_FETCH1;
      ST_FETCH1: state_nxt = ST_MIX;
      ST_MIX:    state_nxt = ST_GAIN;
      ST_GAIN:   state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      newest_idx_r <= '0;
      newest_vld_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + SLOT_W'(1);
      end
      // Keep the highest index written, whatever the write order.
      if (wr_acc && (!newest_vld_r || (in_sample_index > newest_idx_r))) begin
        newest_idx_r <= in_sample_index;
        newest_vld_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the read request and the newest-index view it must report.
  always_ff @(posedge clk) begin
    if (rd_acc) begin
      k0_r       <= pos_diff[POS_W-1:FRAC_W];
      frac_r     <= pos_diff[FRAC_W-1:0];
      neg_r      <= pos_diff[POS_W];
      gain_r     <= in_gain;
      snap_idx_r <= newest_idx_r;
      snap_vld_r <= newest_vld_r;
    end
    if (out_load) begin
      out_sample_r     <= y_sat;
      out_missed_r     <= missed;
      out_newest_idx_r <= snap_vld_r ? snap_idx_r : '0;
      out_newest_vld_r <= snap_vld_r;
    end
  end

  // Tag memory: cleared by the sweep, then written with every sample.
  assign tag_we    = (state_r == ST_CLEAR) || wr_acc;
  assign tag_waddr = (state_r == ST_CLEAR) ? clr_cnt_r : in_sample_index[SLOT_W-1:0];
  assign tag_wdata = (state_r == ST_CLEAR) ? '0 :
                     {1'b1, in_sample_index[IDX_W-1:SLOT_W]};

  // Present the lower neighbour first, then the upper one.
  assign rd_addr = (state_r == ST_FETCH1) ? k1[SLOT_W-1:0] : k0_r[SLOT_W-1:0];

  fdlr_ram #(
    .WIDTH(TAG_W),
    .DEPTH(RING_DEPTH)
  ) u_tag_ram (
    .clk  (clk),
    .we   (tag_we),
    .waddr(tag_waddr),
    .wdata(tag_wdata),
    .raddr(rd_addr),
    .rdata(tag_rdata)
  );

  fdlr_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(RING_DEPTH)
  ) u_smp_ram (
    .clk  (clk),
    .we   (wr_acc),
    .waddr(in_sample_index[SLOT_W-1:0]),
    .wdata(in_sample_value),
    .raddr(rd_addr),
    .rdata(smp_rdata)
  );

  assign step.cap0 = (state_r == ST_FETCH1);
  assign step.mix  = (state_r == ST_MIX);
  assign step.gain = (state_r == ST_GAIN);

  fdlr_interp u_interp (
    .clk      (clk),
    .step     (step),
    .tag_rdata(tag_rdata),
    .smp_rdata($signed(smp_rdata)),
    .k0       (k0_r),
    .k1       (k1),
    .frac     (frac_r),
    .neg      (neg_r),
    .gain     (gain_r),
    .y_sat    (y_sat),
    .missed   (missed)
  );

  assign out_valid        = out_valid_r;
  assign out_sample       = out_sample_r;
  assign out_missed       = out_missed_r;
  assign out_newest_index = out_newest_idx_r;
  assign out_newest_valid = out_newest_vld_r;

endmodule
